// File: rtl/brle_pkg.sv
// Shared types and constants of the BMP RLE pixel decoder.
`default_nettype none

package brle_pkg;

  // Largest image dimension taken from the size registers.
  localparam int MaxDim = 4096;
  // Depth of the queue between the parser and the pixel stage.
  localparam int QDepth = 4;
  // Cursor width: holds any dimension up to 8191 plus one byte step.
  localparam int CurW = 14;

  // Input item kinds.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_SPAN  = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [5:0] {
    PH_FIRST  = 6'b000001,
    PH_SECOND = 6'b000010,
    PH_DX     = 6'b000100,
    PH_DY     = 6'b001000,
    PH_ABS    = 6'b010000,
    PH_PAD    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic        rle4;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  // One queued operation: palette write, pixel span or status.
  typedef struct packed {
    logic        is_write;
    logic [1:0]  status;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  count;
    logic [7:0]  idx_a;   // first colour index, or palette entry for a write
    logic [7:0]  idx_b;
    logic [23:0] colour;  // write data
  } op_t;

  // Clamp a size register to the largest supported dimension.
  function automatic logic [12:0] eff_dim(input logic [12:0] v);
    return (32'(v) > MaxDim) ? 13'(MaxDim) : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/brle_front.sv
// Stream parser: tracks cursor and escape phase, turns items into queued operations.
`default_nettype none

module brle_front
  import brle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        accept_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [23:0] entry_colour_i,
  output op_t              op_o,
  output logic             push_o
);

  phase_e           phase_q, phase_d;
  logic [CurW-1:0]  col_q, col_d;
  logic [CurW-1:0]  row_q, row_d;
  logic [7:0]       held_q, held_d;
  logic [7:0]       left_q, left_d;
  logic             pad_q, pad_d;
  logic             stopped_q, stopped_d;

  logic             span_req;
  logic [7:0]       span_n;
  logic [7:0]       span_a;
  logic [7:0]       span_b;
  logic             stat_req;
  logic [1:0]       stat_code;
  logic [12:0]      w_eff;
  logic [12:0]      h_eff;
  logic [CurW-1:0]  span_end;
  logic             four;
  logic [7:0]       b;
  logic [7:0]       abs_n;

  assign w_eff    = eff_dim(cfg_i.width);
  assign h_eff    = eff_dim(cfg_i.height);
  assign four     = cfg_i.rle4;
  assign b        = data_byte_i;
  assign span_end = col_q + CurW'(span_n);
  assign abs_n    = (four && left_q >= 8'd2) ? 8'd2 : 8'd1;

  always_comb begin
    phase_d   = phase_q;
    col_d     = col_q;
    row_d     = row_q;
    held_d    = held_q;
    left_d    = left_q;
    pad_d     = pad_q;
    stopped_d = stopped_q;
    span_req  = 1'b0;
    span_n    = '0;
    span_a    = '0;
    span_b    = '0;
    stat_req  = 1'b0;
    stat_code = ST_ERROR;
    op_o      = '0;
    push_o    = 1'b0;

    if (accept_i) begin
      unique case (command_i)
        CMD_LOAD: begin
          push_o        = 1'b1;
          op_o.is_write = 1'b1;
          op_o.idx_a    = entry_index_i;
          op_o.colour   = entry_colour_i;
        end
        CMD_START: begin
          phase_d   = PH_FIRST;
          col_d     = '0;
          row_d     = '0;
          held_d    = '0;
          left_d    = '0;
          pad_d     = 1'b0;
          stopped_d = 1'b0;
        end
        CMD_DATA: begin
          if (!stopped_q) begin
            unique case (phase_q)
              PH_FIRST: begin
                held_d  = b;
                phase_d = PH_SECOND;
              end
              PH_SECOND: begin
                phase_d = PH_FIRST;
                if (held_q != 8'd0) begin
                  span_req = 1'b1;
                  span_n   = held_q;
                  span_a   = four ? {4'd0, b[7:4]} : b;
                  span_b   = four ? {4'd0, b[3:0]} : b;
                end else if (b == 8'h00) begin
                  // end of line
                  if (row_q >= CurW'(h_eff)) begin
                    stat_req = 1'b1;
                  end else begin
                    col_d = '0;
                    row_d = row_q + CurW'(1);
                  end
                end else if (b == 8'h01) begin
                  stat_req  = 1'b1;
                  stat_code = ST_END;
                end else if (b == 8'h02) begin
                  phase_d = PH_DX;
                end else begin
                  left_d  = b;
                  // pad when the group uses an odd number of bytes
                  pad_d   = four ? (b[1] ^ b[0]) : b[0];
                  phase_d = PH_ABS;
                end
              end
              PH_DX: begin
                held_d  = b;
                phase_d = PH_DY;
              end
              PH_DY: begin
                phase_d = PH_FIRST;
                col_d   = col_q + CurW'(held_q);
                row_d   = row_q + CurW'(b);
                if (col_d >= CurW'(w_eff) || row_d >= CurW'(h_eff)) stat_req = 1'b1;
              end
              PH_ABS: begin
                left_d = (left_q >= abs_n) ? left_q - abs_n : 8'd0;
                if (left_d == 8'd0) phase_d = pad_q ? PH_PAD : PH_FIRST;
                span_req = 1'b1;
                span_n   = abs_n;
                span_a   = four ? {4'd0, b[7:4]} : b;
                if (!four) span_b = b;
                else if (abs_n == 8'd2) span_b = {4'd0, b[3:0]};
                else span_b = {4'd0, b[7:4]};
              end
              PH_PAD: begin
                phase_d = PH_FIRST;
              end
              default: begin
                phase_d = PH_FIRST;
              end
            endcase
          end
        end
        default: ;
      endcase

      if (span_req) begin
        if (row_q >= CurW'(h_eff) || span_end > CurW'(w_eff)) begin
          stat_req = 1'b1;
        end else begin
          push_o      = 1'b1;
          op_o.status = ST_SPAN;
          op_o.row    = row_q[11:0];
          op_o.column = col_q[11:0];
          op_o.count  = span_n;
          op_o.idx_a  = span_a;
          op_o.idx_b  = span_b;
          col_d       = span_end;
        end
      end

      if (stat_req) begin
        push_o      = 1'b1;
        op_o.status = stat_code;
        stopped_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      col_q     <= '0;
      row_q     <= '0;
      held_q    <= '0;
      left_q    <= '0;
      pad_q     <= 1'b0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      col_q     <= col_d;
      row_q     <= row_d;
      held_q    <= held_d;
      left_q    <= left_d;
      pad_q     <= pad_d;
      stopped_q <= stopped_d;
    end
  end

  // once stopped, only palette writes may be queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stopped_q && push_o) |-> op_o.is_write)
    else $error("span or status queued while stopped");

  // a queued span always lies inside the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !op_o.is_write && op_o.status == ST_SPAN) |-> (span_end <= CurW'(w_eff)))
    else $error("span passes row end");

endmodule

`default_nettype wire

// File: rtl/brle_queue.sv
// Short FIFO of parsed operations between parser and pixel stage.
`default_nettype none

module brle_queue
  import brle_pkg::*;
#(
  parameter int DEPTH = QDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  input  wire logic pop_i,
  output op_t       op_o,
  output logic      valid_o,
  output logic      full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  op_t             mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

`default_nettype wire

// File: rtl/brle_back.sv
// Pixel stage: palette memory, colour lookup and output register.
`default_nettype none

module brle_back
  import brle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire op_t         op_i,
  input  wire logic        op_valid_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [1:0]       m_status_o,
  output logic [79:0]      m_data_o
);

  logic [23:0] pal_q [256];
  logic [23:0] col_a_q, col_b_q;
  op_t         out_q;
  logic        out_valid_q;
  logic        advance;
  logic        head_out;
  logic        is_span;
  logic [23:0] col_a, col_b;

  assign advance  = !out_valid_q || m_ready_i;
  assign head_out = op_valid_i && !op_i.is_write;
  // palette writes drain even while the output is stalled
  assign pop_o    = op_valid_i && (op_i.is_write || advance);

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_i.is_write) pal_q[op_i.idx_a] <= op_i.colour;
  end

  always_ff @(posedge clk_i) begin
    if (advance && head_out) begin
      col_a_q <= pal_q[op_i.idx_a];
      col_b_q <= pal_q[op_i.idx_b];
      out_q   <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= head_out;
    end
  end

  assign is_span    = (out_q.status == ST_SPAN);
  assign col_a      = is_span ? col_a_q : 24'd0;
  assign col_b      = is_span ? col_b_q : 24'd0;
  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_q.status;
  assign m_data_o   = {col_b[7:0], col_b[15:8], col_b[23:16],
                       col_a[7:0], col_a[15:8], col_a[23:16],
                       out_q.count, out_q.column, out_q.row};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !out_q.is_write)
    else $error("palette write reached the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !is_span) |-> (out_q.count == 8'd0 && out_q.row == 12'd0))
    else $error("status result carries span fields");

endmodule

`default_nettype wire

// File: rtl/bmp_rle_pixel_decoder.sv
// BMP RLE8/RLE4 pixel-span decoder: top level with configuration registers.
//
// Input stream: s_axis_tuser carries the command (palette load, data byte,
// start image); s_axis_tdata carries the byte and the palette entry fields.
// Output stream: one result per run or absolute byte (a pixel span with its
// two colours), or an end-of-bitmap or error status in m_axis_tuser.
// Configuration: cfg_we_i writes register cfg_addr_i (0 mode, 1 width,
// 2 height) with cfg_wdata_i; write only while the decoder is idle.
// Throughput: one item per cycle while the queue is not full. The parser
// settles cursor, phase and range checks in the cycle an item is accepted;
// the pixel stage pops one queued operation per cycle while the output
// register is free or being taken, so sustained rate is set by the single
// palette port pair and the output register. With an empty queue, an
// accepted item is written into the queue, then its colours are read from
// the palette into the output register, which offers the result.
// Stalls: when m_axis_tready is low the output register holds, the queue
// fills (palette loads at its head still drain) and s_axis_tready drops once
// it is full.
// Reset clears cursor, parser and queue; size registers reset to 4096 and
// mode to RLE8. Palette contents are undefined until loaded.
`default_nettype none

module bmp_rle_pixel_decoder
  import brle_pkg::*;
#(
  parameter int QUEUE_DEPTH = QDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // data_byte[7:0], entry_index[15:8], entry_red[23:16], entry_green[31:24],
  // entry_blue[39:32]
  input  wire logic [39:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // row[11:0], column[23:12], count[31:24], first_red[39:32],
  // first_green[47:40], first_blue[55:48], second_red[63:56],
  // second_green[71:64], second_blue[79:72]
  output logic [79:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [12:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic accept;
  logic push;
  op_t  op_in;
  op_t  op_head;
  logic q_valid;
  logic q_full;
  logic pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle4   <= 1'b0;
      cfg_q.width  <= 13'd4096;
      cfg_q.height <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MODE:   cfg_q.rle4   <= cfg_wdata_i[0];
        REG_WIDTH:  cfg_q.width  <= cfg_wdata_i;
        REG_HEIGHT: cfg_q.height <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // palette colour is held as {red, green, blue}
  brle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .command_i      (s_axis_tuser),
    .data_byte_i    (s_axis_tdata[7:0]),
    .entry_index_i  (s_axis_tdata[15:8]),
    .entry_colour_i ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .op_o           (op_in),
    .push_o         (push)
  );

  brle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .pop_i   (pop),
    .op_o    (op_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  brle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_head),
    .op_valid_i (q_valid),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_status_o (m_axis_tuser),
    .m_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the BMP RLE8/RLE4 pixel-span decoder.
`timescale 1ns / 100ps

module tb;
  import brle_pkg::*;

  localparam logic [1:0] CMD_NONE  = 2'd3;   // unused command code
  localparam logic [7:0] ESC_MARK  = 8'h00;  // first byte of an escape pair
  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;
  localparam int         PHASES    = 9;
  localparam int         PHASE_ITEMS = 165;

  // Span fields as packed in m_axis_tdata (row in the low bits).
  typedef struct packed {
    logic [7:0]  second_blue;
    logic [7:0]  second_green;
    logic [7:0]  second_red;
    logic [7:0]  first_blue;
    logic [7:0]  first_green;
    logic [7:0]  first_red;
    logic [7:0]  count;
    logic [11:0] column;
    logic [11:0] row;
  } span_t;

  typedef struct packed {
    logic [1:0] status;
    span_t      span;
  } result_t;

  class rle_scoreboard;
    logic        rle4;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] palette [256];
    int unsigned col;
    int unsigned row;
    phase_e      phase;
    logic [7:0]  held;
    int unsigned left;
    logic        pad;
    logic        stopped;
    result_t     spans_due [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      rle4 = 1'b0;
      width_reg = 13'd4096;
      height_reg = 13'd4096;
      foreach (palette[i]) palette[i] = '0;
      mismatches = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      col = 0;
      row = 0;
      phase = PH_FIRST;
      held = '0;
      left = 0;
      pad = 1'b0;
      stopped = 1'b0;
    endfunction

    function int unsigned eff_width();
      return (width_reg > MaxDim) ? MaxDim : width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg > MaxDim) ? MaxDim : height_reg;
    endfunction

    function void write_reg(logic [1:0] addr, logic [12:0] value);
      case (addr)
        REG_MODE:   rle4 = value[0];
        REG_WIDTH:  width_reg = value;
        REG_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function void push_status(logic [1:0] st);
      result_t r;
      r = '0;
      r.status = st;
      spans_due.push_back(r);
      stopped = 1'b1;
    endfunction

    function void push_span(int unsigned n, logic [7:0] ia, logic [7:0] ib);
      result_t r;
      if (row >= eff_height() || col + n > eff_width()) begin
        push_status(ST_ERROR);
        return;
      end
      r.status = ST_SPAN;
      r.span.row = row[11:0];
      r.span.column = col[11:0];
      r.span.count = n[7:0];
      {r.span.first_red, r.span.first_green, r.span.first_blue} = palette[ia];
      {r.span.second_red, r.span.second_green, r.span.second_blue} = palette[ib];
      spans_due.push_back(r);
      col += n;
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned n;
      int unsigned nbytes;
      case (phase)
        PH_FIRST: begin
          held = b;
          phase = PH_SECOND;
        end
        PH_SECOND: begin
          phase = PH_FIRST;
          if (held != 0) begin
            if (rle4) push_span(held, b[7:4], b[3:0]);
            else push_span(held, b, b);
          end else if (b == ESC_EOL) begin
            if (row >= eff_height()) push_status(ST_ERROR);
            else begin
              col = 0;
              row++;
            end
          end else if (b == ESC_EOB) begin
            push_status(ST_END);
          end else if (b == ESC_DELTA) begin
            phase = PH_DX;
          end else begin
            left = b;
            // pad decided up front: odd number of group bytes
            nbytes = rle4 ? (int'(b) + 1) / 2 : int'(b);
            pad = nbytes[0];
            phase = PH_ABS;
          end
        end
        PH_DX: begin
          held = b;
          phase = PH_DY;
        end
        PH_DY: begin
          phase = PH_FIRST;
          col += held;
          row += b;
          if (col >= eff_width() || row >= eff_height()) push_status(ST_ERROR);
        end
        PH_ABS: begin
          n = (rle4 && left >= 2) ? 2 : 1;
          left -= n;
          if (left == 0) phase = pad ? PH_PAD : PH_FIRST;
          if (!rle4) push_span(1, b, b);
          else if (n == 2) push_span(2, b[7:4], b[3:0]);
          else push_span(1, b[7:4], b[7:4]);
        end
        default: phase = PH_FIRST;
      endcase
    endfunction

    function void note_item(logic [1:0] cmd, logic [39:0] data);
      if (cmd == CMD_LOAD) palette[data[15:8]] = {data[23:16], data[31:24], data[39:32]};
      else if (cmd == CMD_START) restart();
      else if (cmd == CMD_DATA && !stopped) take_byte(data[7:0]);
    endfunction

    function void compare(string name, logic [11:0] want, logic [11:0] seen);
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %0h got %0h", checked, name, want, seen);
      end
    endfunction

    function void check_span(logic [1:0] status, logic [79:0] data);
      result_t want;
      span_t   got;
      got = data;
      if (spans_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0h data %h", status, data);
        return;
      end
      want = spans_due.pop_front();
      compare("status", want.status, status);
      compare("row", want.span.row, got.row);
      compare("column", want.span.column, got.column);
      compare("count", want.span.count, got.count);
      compare("first_red", want.span.first_red, got.first_red);
      compare("first_green", want.span.first_green, got.first_green);
      compare("first_blue", want.span.first_blue, got.first_blue);
      compare("second_red", want.span.second_red, got.second_red);
      compare("second_green", want.span.second_green, got.second_green);
      compare("second_blue", want.span.second_blue, got.second_blue);
      checked++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [12:0] cfg_wdata_i;

  rle_scoreboard sb;
  int unsigned   items_sent;
  bit            in_burst;
  bit            out_burst;

  bmp_rle_pixel_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [39:0] rand40();
    return {$urandom(), 8'($urandom())};
  endfunction

  // Length in lo..min(room, 255), mostly short.
  function automatic int unsigned pick_len(int unsigned lo, int unsigned room);
    int unsigned hi;
    hi = (room > 255) ? 255 : room;
    if ($urandom_range(0, 3) == 0) return $urandom_range(lo, hi);
    return $urandom_range(lo, (hi > lo + 15) ? lo + 15 : hi);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [39:0] data);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(cmd, data);
    if (cmd != CMD_NONE) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_data(input logic [7:0] b);
    logic [39:0] d;
    d = rand40();   // entry fields carry noise on data items
    d[7:0] = b;
    send_item(CMD_DATA, d);
  endtask

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
    send_data(a);
    send_data(b);
  endtask

  task automatic send_load(input logic [7:0] idx);
    logic [39:0] d;
    d = rand40();
    d[15:8] = idx;
    send_item(CMD_LOAD, d);
  endtask

  task automatic send_start();
    send_item(CMD_START, rand40());
  endtask

  // Lets the queue empty out, palette writes included, before a register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.spans_due.size() != 0) @(negedge clk_i);
    repeat (2 * QDepth + 8) @(negedge clk_i);
  endtask

  task automatic configure(input logic mode, input logic [12:0] w, input logic [12:0] h);
    logic [1:0]  addrs [3];
    logic [12:0] vals [3];
    addrs = '{REG_MODE, REG_WIDTH, REG_HEIGHT};
    vals = '{{12'd0, mode}, w, h};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= addrs[i];
      cfg_wdata_i <= vals[i];
      sb.write_reg(addrs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic directed();
    // RLE8 at reset sizes
    send_pair(8'd255, 8'hFF);          // longest run, top palette entry
    send_pair(8'd1, 8'h00);            // shortest run, entry zero
    send_pair(ESC_MARK, ESC_DELTA);
    send_pair(8'd255, 8'd255);
    send_item(CMD_NONE, rand40());
    send_pair(ESC_MARK, ESC_EOB);
    send_data(8'h07);                  // dropped while stopped
    send_start();
    drain();
    // RLE4 on a 16 x 2 image
    configure(1'b1, 13'd16, 13'd2);
    send_pair(8'd17, 8'h5A);           // one pixel past the row end
    send_start();
    send_pair(ESC_MARK, 8'd5);         // odd group: spans of 2, 2, 1 then pad
    repeat (3) send_data(8'($urandom()));
    send_data(8'($urandom()));
    send_pair(8'd11, 8'hA5);           // fills the row exactly
    send_pair(ESC_MARK, ESC_EOL);
    send_pair(ESC_MARK, ESC_EOL);
    send_pair(ESC_MARK, ESC_EOL);      // end of line below the last row
  endtask

  task automatic random_op();
    int unsigned roll;
    int unsigned room;
    int unsigned n;
    int unsigned nbytes;
    int unsigned dx;
    int unsigned dy;
    int unsigned h;
    roll = $urandom_range(0, 99);
    h = sb.eff_height();
    room = (sb.col < sb.eff_width()) ? sb.eff_width() - sb.col : 0;
    if (sb.stopped && roll < 85) begin
      send_start();
    end else if (roll < 4) begin
      send_load(8'($urandom()));
    end else if (roll < 6) begin
      send_item(CMD_NONE, rand40());
    end else if (roll < 8 || sb.phase != PH_FIRST) begin
      send_data(8'($urandom()));       // breaks the pairing
    end else if (roll < 9) begin
      send_start();
    end else if (roll < 50) begin
      if (room > 0 && $urandom_range(0, 9) != 0) n = pick_len(1, room);
      else n = $urandom_range(1, 255);
      send_pair(n[7:0], 8'($urandom()));
    end else if (roll < 70) begin
      if (room >= 3 && $urandom_range(0, 9) != 0) n = pick_len(3, room);
      else n = $urandom_range(3, 255);
      nbytes = sb.rle4 ? (n + 1) / 2 : n;
      send_pair(ESC_MARK, n[7:0]);
      repeat (nbytes) send_data(8'($urandom()));
      if (nbytes[0]) send_data(8'($urandom()));
    end else if (roll < 84) begin
      send_pair(ESC_MARK, ESC_EOL);
    end else if (roll < 94) begin
      if (room > 0 && sb.row < h && $urandom_range(0, 7) != 0) begin
        dx = $urandom_range(0, (room - 1 > 255) ? 255 : room - 1);
        dy = $urandom_range(0, (h - 1 - sb.row > 2) ? 2 : h - 1 - sb.row);
      end else begin
        dx = $urandom_range(0, 255);
        dy = $urandom_range(0, 255);
      end
      send_pair(ESC_MARK, ESC_DELTA);
      send_pair(dx[7:0], dy[7:0]);
    end else if (roll < 97) begin
      send_pair(ESC_MARK, ESC_EOB);
    end else begin
      send_load(8'($urandom()));
    end
  endtask

  initial begin : stimulus
    logic        modes [PHASES];
    logic [12:0] widths [PHASES];
    logic [12:0] heights [PHASES];
    int unsigned target;
    sb = new();
    items_sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_LOAD;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_MODE;
    cfg_wdata_i = '0;
    modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    widths = '{13'd4096, 13'($urandom_range(2, 400)), 13'd1, 13'd8191, 13'd16,
               13'd4096, 13'd0, 13'd4095, 13'($urandom_range(2, 400))};
    heights = '{13'd4096, 13'd4096, 13'd1, 13'd6, 13'd3,
                13'd4096, 13'd4096, 13'd8191, 13'd0};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // every palette entry is defined before any pixel is decoded
    for (int i = 0; i < 256; i++) send_load(8'(i));
    directed();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(modes[p], widths[p], heights[p]);
      if ($urandom_range(0, 1) != 0) send_start();
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_op();
    end
    drain();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold_mark;
    int unsigned gap;
    hold_mark = 500;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      // long back-pressure while the sender keeps going
      if (hold_mark != 0 && items_sent >= hold_mark) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_mark = (hold_mark < 1000) ? 1300 : 0;
      end
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_span(m_axis_tuser, m_axis_tdata);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
